// File: rtl/asat_pkg.sv
// Shared types and constants for the aliquot-sum amicable test block.
`default_nettype none
package asat_pkg;

	localparam int LIMIT_W     = 16;
	localparam int SUM_OUT_W   = 18;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10000;

	// controller -> datapath commands
	typedef struct packed {
		logic load_p1;     // latch request value, start first pass
		logic load_p2;     // start partner pass on saved sum
		logic div_start;   // seed divider for current candidate
		logic div_step;    // one restoring-divide bit
		logic accum;       // add divisor pair if it divides, advance candidate
		logic save_s;      // store first-pass proper divisor sum
		logic latch_match; // amicable flag from partner pass
		logic clear_amic;  // amicable flag forced low
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic operand_zero;
		logic sq_le;       // candidate squared <= operand
		logic div_last;    // final divide bit this cycle
		logic partner_ok;  // sum within limit and differs from value
	} status_t;

endpackage
`default_nettype wire

// File: rtl/asat_dp.sv
// Datapath: limit register, candidate/square tracking, serial divider, sums.
`default_nettype none
module asat_dp #(
	parameter int VALUE_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [VALUE_WIDTH-1:0]         value,
	input  wire logic                           cfg_valid,
	input  wire logic [asat_pkg::LIMIT_W-1:0]   cfg_data,
	input  wire asat_pkg::cmd_t                 cmd,
	output asat_pkg::status_t                   status,
	output logic [asat_pkg::SUM_OUT_W-1:0]      divisor_sum,
	output logic                                amicable
);
	import asat_pkg::*;

	localparam int NW    = (VALUE_WIDTH > LIMIT_W) ? VALUE_WIDTH : LIMIT_W;
	localparam int DW    = NW / 2 + 1;
	localparam int SQ_W  = 2 * DW + 1;
	localparam int SUM_W = NW + 3;
	localparam int CNT_W = $clog2(NW);

	logic [LIMIT_W-1:0] limit_q;
	logic [NW-1:0]      n_q;
	logic [NW-1:0]      op_q;
	logic [DW-1:0]      d_q;
	logic [SQ_W-1:0]    sq_q;
	logic [SUM_W-1:0]   acc_q;
	logic [DW-1:0]      rem_q;
	logic [NW-1:0]      quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   s_q;
	logic               amic_q;

	logic [DW:0]        rem_sh;
	logic [DW:0]        rem_diff;
	logic               rem_ge;
	logic [SUM_W-1:0]   pair_add;
	logic [SUM_W-1:0]   net_sum;

	assign rem_sh   = {rem_q, quo_q[NW-1]};
	assign rem_diff = rem_sh - {1'b0, d_q};
	assign rem_ge   = (rem_sh >= {1'b0, d_q});
	// square root divisor counted once
	assign pair_add = (quo_q == NW'(d_q)) ? SUM_W'(d_q) : (SUM_W'(d_q) + SUM_W'(quo_q));
	assign net_sum  = acc_q - SUM_W'(op_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_p1) begin
			n_q   <= NW'(value);
			op_q  <= NW'(value);
			d_q   <= DW'(1);
			sq_q  <= SQ_W'(1);
			acc_q <= '0;
		end
		if (cmd.load_p2) begin
			op_q  <= NW'(s_q[LIMIT_W-1:0]);
			d_q   <= DW'(1);
			sq_q  <= SQ_W'(1);
			acc_q <= '0;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= op_q;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], rem_ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.accum) begin
			if (rem_q == '0) begin
				acc_q <= acc_q + pair_add;
			end
			d_q  <= d_q + DW'(1);
			sq_q <= sq_q + SQ_W'({d_q, 1'b1});
		end
		if (cmd.save_s) begin
			s_q <= net_sum;
		end
		if (cmd.latch_match) begin
			amic_q <= (net_sum == SUM_W'(n_q));
		end
		if (cmd.clear_amic) begin
			amic_q <= 1'b0;
		end
	end

	assign status.operand_zero = (op_q == '0);
	assign status.sq_le        = (sq_q <= SQ_W'(op_q));
	assign status.div_last     = (cnt_q == CNT_W'(NW - 1));
	assign status.partner_ok   = (s_q <= SUM_W'(limit_q)) && (s_q != SUM_W'(n_q));

	assign divisor_sum = (s_q > SUM_W'({SUM_OUT_W{1'b1}})) ? {SUM_OUT_W{1'b1}}
	                                                      : s_q[SUM_OUT_W-1:0];
	assign amicable = amic_q;

endmodule
`default_nettype wire

// File: rtl/asat_ctrl.sv
// Controller: sequences the two trial-division passes and the result strobe.
`default_nettype none
module asat_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire asat_pkg::status_t status,
	output asat_pkg::cmd_t         cmd,
	output logic                   busy,
	output logic                   done
);
	import asat_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_ACC,
		S_FINISH,
		S_DECIDE,
		S_OUT
	} state_t;

	state_t state_q;
	logic   pass_q;   // 0: value pass, 1: partner pass

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_CHECK;
						pass_q  <= 1'b0;
					end
				end
				S_CHECK: begin
					if (status.operand_zero || !status.sq_le) state_q <= S_FINISH;
					else state_q <= S_DIV;
				end
				S_DIV: begin
					if (status.div_last) state_q <= S_ACC;
				end
				S_ACC: state_q <= S_CHECK;
				S_FINISH: begin
					if (pass_q) state_q <= S_OUT;
					else state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (status.partner_ok) begin
						state_q <= S_CHECK;
						pass_q  <= 1'b1;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.load_p1 = start;
			S_CHECK:  cmd.div_start = !status.operand_zero && status.sq_le;
			S_DIV:    cmd.div_step = 1'b1;
			S_ACC:    cmd.accum = 1'b1;
			S_FINISH: begin
				cmd.save_s      = !pass_q;
				cmd.latch_match = pass_q;
			end
			S_DECIDE: begin
				cmd.load_p2    = status.partner_ok;
				cmd.clear_amic = !status.partner_ok;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

endmodule
`default_nettype wire

// File: rtl/aliquot_sum_amicable_test.sv
// Top level: aliquot sum of a value and amicable-pair test within a limit.
// Done rises after the first pass, or after the partner pass when that runs. The first
//   pass tries candidates d = 1 to r1 = floor(sqrt(value)), the partner pass d = 1 to
//   r2 = floor(sqrt(sum)); NW = max(VALUE_WIDTH, 16). Each candidate divisor gets a
//   check, NW serial divide bits and an accumulate.
// Throughput: one request at a time, the next taken the cycle after the one-cycle
//   done strobe; the receiver cannot stall the result.
// Reset (arst_n low, async): controller idles, partner_limit returns to 10000.
`default_nettype none
module aliquot_sum_amicable_test #(
	parameter int VALUE_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request channel
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [VALUE_WIDTH-1:0]         value,
	// result, valid for the single cycle done is high
	output logic                                done,
	output logic [asat_pkg::SUM_OUT_W-1:0]      divisor_sum,
	output logic                                amicable,
	// partner_limit write channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [asat_pkg::LIMIT_W-1:0]   cfg_data
);
	import asat_pkg::*;

	cmd_t    cmd;
	status_t status;

	// limit register always takes writes; the user must issue writes only while idle, the block itself does not enforce it
	assign cfg_ready = 1'b1;

	// Sequencer: first pass sums divisor pairs of value; if that sum is a
	// plausible partner, a second pass sums divisors of the sum and compares.
	asat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath: candidate d and d*d tracked incrementally (no square root),
	// one shared restoring divider gives quotient and remainder per candidate.
	asat_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.divisor_sum (divisor_sum),
		.amicable    (amicable)
	);

endmodule
`default_nettype wire

// File: verif/aliquot_sum_amicable_test_tb.sv
// Testbench for the aliquot-sum amicable test block: directed table, then random requests.
`default_nettype none
module aliquot_sum_amicable_test_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import asat_pkg::*;

	localparam int VALUE_W       = 16;
	// Longest request: 255 + 255 candidates, each with a full serial divide, with
	// nothing moving. The limit allows several times that, plus sender gaps.
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int SETTLE_CYCLES  = 24;

	// one expected result
	typedef struct packed {
		logic [SUM_OUT_W-1:0] dsum;
		logic                 amic;
	} outcome_t;

	// directed table: either a request or a new partner limit
	typedef enum logic {ROW_REQ, ROW_LIMIT} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [15:0]          data;   // request value or limit
		logic                 typed;  // expectation given below, else predicted
		logic [SUM_OUT_W-1:0] dsum;
		logic                 amic;
	} stim_row_t;

	localparam int N_ROWS = 27;

	// Typed rows are the ones readable at a glance: zero and one, primes,
	// perfect numbers (sum equals value, never amicable), a square, known pairs
	// on both sides of the limit, and the zero limit that blocks every pair.
	stim_row_t directed_rows [N_ROWS] = '{
		'{ROW_REQ,   16'd0,     1'b1, 18'd0,     1'b0},
		'{ROW_REQ,   16'd1,     1'b1, 18'd0,     1'b0},
		'{ROW_REQ,   16'd2,     1'b1, 18'd1,     1'b0},
		'{ROW_REQ,   16'd6,     1'b1, 18'd6,     1'b0},
		'{ROW_REQ,   16'd36,    1'b1, 18'd55,    1'b0},
		'{ROW_REQ,   16'd220,   1'b1, 18'd284,   1'b1},
		'{ROW_REQ,   16'd284,   1'b1, 18'd220,   1'b1},
		'{ROW_REQ,   16'd8128,  1'b1, 18'd8128,  1'b0},
		'{ROW_REQ,   16'd17296, 1'b1, 18'd18416, 1'b0},
		'{ROW_REQ,   16'd12285, 1'b0, 18'd0,     1'b0},
		'{ROW_REQ,   16'd65521, 1'b1, 18'd1,     1'b0},
		'{ROW_REQ,   16'd65535, 1'b0, 18'd0,     1'b0},
		'{ROW_REQ,   16'd65025, 1'b0, 18'd0,     1'b0},
		'{ROW_REQ,   16'hAAAA,  1'b0, 18'd0,     1'b0},
		'{ROW_REQ,   16'h5555,  1'b0, 18'd0,     1'b0},
		'{ROW_LIMIT, 16'd65535, 1'b0, 18'd0,     1'b0},
		'{ROW_REQ,   16'd17296, 1'b1, 18'd18416, 1'b1},
		'{ROW_REQ,   16'd12285, 1'b1, 18'd14595, 1'b1},
		'{ROW_REQ,   16'd63020, 1'b1, 18'd76084, 1'b0},
		'{ROW_REQ,   16'd65535, 1'b0, 18'd0,     1'b0},
		'{ROW_LIMIT, 16'd283,   1'b0, 18'd0,     1'b0},
		'{ROW_REQ,   16'd220,   1'b1, 18'd284,   1'b0},
		'{ROW_REQ,   16'd284,   1'b1, 18'd220,   1'b1},
		'{ROW_LIMIT, 16'd0,     1'b0, 18'd0,     1'b0},
		'{ROW_REQ,   16'd284,   1'b1, 18'd220,   1'b0},
		'{ROW_REQ,   16'd1,     1'b1, 18'd0,     1'b0},
		'{ROW_REQ,   16'd220,   1'b1, 18'd284,   1'b0}
	};

	// members of amicable pairs, plus a member whose partner is beyond 16 bits (63020)
	localparam int N_PAIRS = 17;
	logic [15:0] pair_members [N_PAIRS] = '{
		16'd220, 16'd284, 16'd1184, 16'd1210, 16'd2620, 16'd2924, 16'd5020,
		16'd5564, 16'd6232, 16'd6368, 16'd10744, 16'd10856, 16'd12285,
		16'd14595, 16'd17296, 16'd18416, 16'd63020
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [VALUE_W-1:0]   value = '0;
	logic                 done;
	logic [SUM_OUT_W-1:0] divisor_sum;
	logic                 amicable;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [LIMIT_W-1:0]   cfg_data = '0;

	logic [LIMIT_W-1:0]   limit_shadow = LIMIT_RESET;
	outcome_t             pending_outcomes [$];
	int                   error_count = 0;
	int                   quiet_cycles = 0;

	aliquot_sum_amicable_test #(.VALUE_WIDTH(VALUE_W)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.done        (done),
		.divisor_sum (divisor_sum),
		.amicable    (amicable),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sum of proper divisors by trial division up to floor(sqrt(n)); the root of
	// a perfect square is counted once. Zero maps to zero.
	function automatic longint unsigned aliquot_of(longint unsigned n);
		longint unsigned root, acc, d;
		if (n == 0)
			return 0;
		root = 0;
		while ((root + 1) * (root + 1) <= n)
			root++;
		acc = 0;
		for (d = 1; d <= root; d++)
			if (n % d == 0)
				acc += d + n / d;
		acc -= n;
		if (root * root == n)
			acc -= root;
		return acc;
	endfunction

	// Amicable: sum within the limit, not the value itself, and its own sum
	// leads back to the value.
	function automatic outcome_t predict_outcome(logic [VALUE_W-1:0] v);
		longint unsigned n, s;
		outcome_t o;
		n = v;
		s = aliquot_of(n);
		o.dsum = (s > 64'(2**SUM_OUT_W - 1)) ? '1 : s[SUM_OUT_W-1:0];
		o.amic = (s <= limit_shadow) && (s != n) && (aliquot_of(s) == n);
		return o;
	endfunction

	// Mostly small values keep the run short; pair members reach the amicable
	// path, a few full-width values cover every bit and the longest loops.
	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return pair_members[$urandom_range(0, N_PAIRS - 1)];
		if (r < 14)
			return VALUE_W'($urandom_range(0, 65535));
		if (r < 16)
			return pair_members[$urandom_range(0, N_PAIRS - 1)] ^ VALUE_W'(1 << $urandom_range(0, 3));
		return VALUE_W'($urandom_range(0, 511));
	endfunction

	// Raise start and hold it until the block takes the request. start stays
	// high afterwards, so a back-to-back request does not need start to drop and rise again.
	task automatic issue_request(logic [VALUE_W-1:0] v, logic typed, outcome_t given);
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy);
		pending_outcomes.push_back(typed ? given : predict_outcome(v));
	endtask

	// Stop sending and wait until every result is in and the block is idle.
	task automatic settle();
		start <= 1'b0;
		while (pending_outcomes.size() != 0 || busy)
			@(posedge clk);
	endtask

	// One write of partner_limit; only called after settle().
	task automatic write_limit(logic [LIMIT_W-1:0] lim);
		cfg_valid <= 1'b1;
		cfg_data  <= lim;
		do
			@(posedge clk);
		while (!cfg_ready);
		limit_shadow = lim;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random phase: sender idles idle_pct percent of cycles before each request,
	// and every 100 requests it stops until every result is in and the block is idle.
	task automatic random_phase(int idle_pct, int n_items);
		for (int i = 0; i < n_items; i++) begin
			while ($urandom_range(0, 99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
			issue_request(pick_value(), 1'b0, '0);
			if (i % 100 == 99)
				settle();
		end
		settle();
	endtask

	// Result checker and watchdog. Outputs are sampled at the edge that ends the
	// done cycle, so the block's own updates at that edge are not yet visible.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no request waiting: divisor_sum %0d amicable %0b",
					divisor_sum, amicable);
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (divisor_sum !== want.dsum) begin
					$error("divisor_sum: expected %0d, got %0d", want.dsum, divisor_sum);
					error_count++;
				end
				if (amicable !== want.amic) begin
					$error("amicable: expected %0b, got %0b", want.amic, amicable);
					error_count++;
				end
			end
		end
		// anything moving on any channel resets the watchdog
		if (done || (start && !busy) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("aliquot_sum_amicable_test_tb: done, errors");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		outcome_t given;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, first at the reset limit; limit rows drain the block
		// before writing.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_LIMIT) begin
				settle();
				write_limit(directed_rows[i].data);
			end else begin
				given.dsum = directed_rows[i].dsum;
				given.amic = directed_rows[i].amic;
				issue_request(directed_rows[i].data, directed_rows[i].typed, given);
			end
		end
		settle();

		// Random part: sender busy-ish, then mostly idle, then flat out, each at
		// its own limit (top of range, reset value, random).
		write_limit(16'hFFFF);
		random_phase(22, 330);
		write_limit(LIMIT_RESET);
		random_phase(83, 330);
		write_limit(LIMIT_W'($urandom_range(1, 65535)));
		random_phase(0, 340);

		// catch any stray result after the last one
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("aliquot_sum_amicable_test_tb: done, clean");
		else
			$display("aliquot_sum_amicable_test_tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

// File: aliquot_sum_amicable_test.f
rtl/asat_pkg.sv
rtl/asat_dp.sv
rtl/asat_ctrl.sv
rtl/aliquot_sum_amicable_test.sv
verif/aliquot_sum_amicable_test_tb.sv
